@@ hdl/vptt_pkg.sv @@
// Shared constants, register codes and types of the volume price trend tracker.
`default_nettype none

package vptt_pkg;

	localparam int MAX_WINDOW_DEF = 32;

	// field widths
	localparam int PRICE_W = 32;
	localparam int VOL_W   = 32;
	localparam int VPT_W   = 58;
	localparam int TREND_W = 2;

	// increment datapath
	localparam int FRAC_W    = 16;
	localparam int NUM_W     = PRICE_W + VOL_W;
	localparam int QUO_W     = VPT_W;
	localparam int INC_W     = QUO_W + 1;
	localparam int DIV_STEPS = QUO_W / 2;

	// configuration registers
	localparam int WIN_W      = 6;
	localparam int UP_W       = 8;
	localparam int LO_W       = 7;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 8;

	localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LEN = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_UPPER_PCT  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_LOWER_PCT  = 2'd2;

	localparam logic [WIN_W-1:0] WINDOW_RST = 6'd20;
	localparam logic [UP_W-1:0]  UPPER_RST  = 8'd105;
	localparam logic [LO_W-1:0]  LOWER_RST  = 7'd95;

	localparam int PCT_SCALE = 100;

	localparam logic [TREND_W-1:0] TREND_NEUTRAL = 2'd0;
	localparam logic [TREND_W-1:0] TREND_BULL    = 2'd1;
	localparam logic [TREND_W-1:0] TREND_BEAR    = 2'd2;

	typedef struct packed {
		logic             busy;
		logic             sat;
		logic [QUO_W-1:0] quo;
	} div_st_t;

	typedef struct packed {
		logic clr;
		logic sweep;
		logic push;
	} hist_ctl_t;

endpackage

`default_nettype wire

@@ hdl/vptt_if.sv @@
// Valid/ready channel interfaces for price bars and results.
`default_nettype none

interface vptt_bar_if
	import vptt_pkg::*;
();
	logic               valid;
	logic               ready;
	logic               series_start;
	logic [PRICE_W-1:0] close_price;
	logic [VOL_W-1:0]   bar_volume;

	modport source (output valid, series_start, close_price, bar_volume, input ready);
	modport sink (input valid, series_start, close_price, bar_volume, output ready);
endinterface

interface vptt_res_if
	import vptt_pkg::*;
();
	logic                      valid;
	logic                      ready;
	logic signed [VPT_W-1:0]   vpt_value;
	logic        [TREND_W-1:0] trend_code;

	modport source (output valid, vpt_value, trend_code, input ready);
	modport sink (input valid, vpt_value, trend_code, output ready);
endinterface

`default_nettype wire

@@ hdl/volume_price_trend_tracker.sv @@
// Top level of the volume price trend tracker: sequencer, VPT update, registers.
// Flow from bar transfer to result valid: product, divider load, 29 radix-4 steps,
//   the wait for divider and sweep to go idle, update, trend pipeline, output load.
//   The history sweep reads one lookback entry a cycle beside the divider; a bar on
//   a zero previous close skips the divider and is bounded by the sweep alone.
// Bars: the next bar is taken only in the idle state after the output load;
//   a result held by the sink stalls the load. A series-start bar is handled in the
//   idle state and yields no result.
// Reset clears VPT, last close, ring pointer, count and registers; history memory is not cleared.
`default_nettype none

module volume_price_trend_tracker
	import vptt_pkg::*;
#(
	parameter int MAX_WINDOW = MAX_WINDOW_DEF
)(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_wr_en,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_wr_data,
	vptt_bar_if.sink                   bar_in,
	vptt_res_if.source                 result_out
);

	localparam int CNT_W = $clog2(MAX_WINDOW + 1);
	localparam int SUM_W = VPT_W + CNT_W;
	localparam int LIM_W = (CNT_W > WIN_W) ? CNT_W : WIN_W;
	// headroom for running VPT plus or minus a saturated increment
	localparam int ACC_W = VPT_W + 3;

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_MUL  = 3'd1;
	localparam logic [2:0] S_DIV  = 3'd2;
	localparam logic [2:0] S_WAIT = 3'd3;
	localparam logic [2:0] S_UPD  = 3'd4;
	localparam logic [2:0] S_TRND = 3'd5;
	localparam logic [2:0] S_OUT  = 3'd6;

	logic [2:0] state_q;

	// configuration
	logic [WIN_W-1:0] window_q;
	logic [UP_W-1:0]  upper_q;
	logic [LO_W-1:0]  lower_q;

	// series state
	logic        [PRICE_W-1:0] last_close_q;
	logic signed [VPT_W-1:0]   running_q;

	// bar in flight
	logic [PRICE_W-1:0] close_q;
	logic [VOL_W-1:0]   vol_q;
	logic [PRICE_W-1:0] mag_q;
	logic               neg_q;
	logic [NUM_W-1:0]   num_q;
	logic [NUM_W-1:0]   prod_c;

	// output register
	logic                      res_valid_q;
	logic signed [VPT_W-1:0]   res_vpt_q;
	logic        [TREND_W-1:0] res_trend_q;

	logic                    accept;
	logic                    prev_zero;
	div_st_t                 div_st;
	logic                    div_start;
	hist_ctl_t               hist_ctl;
	logic                    hist_busy;
	logic        [CNT_W-1:0] hist_look;
	logic signed [SUM_W-1:0] hist_prior;
	logic        [CNT_W-1:0] lim;
	logic        [LIM_W-1:0] win_x;
	logic                    trend_done;
	logic      [TREND_W-1:0] trend_code;

	logic        [INC_W-1:0] inc;
	logic signed [ACC_W-1:0] acc;
	logic                    acc_ovf;
	logic signed [VPT_W-1:0] vpt_nx;

	assign bar_in.ready = state_q == S_IDLE;
	assign accept       = bar_in.valid && bar_in.ready;
	assign prev_zero    = last_close_q == '0;
	assign prod_c       = vol_q * mag_q;
	assign div_start    = (state_q == S_DIV) && !prev_zero;

	// window_len above MAX_WINDOW acts as MAX_WINDOW
	always_comb begin
		win_x = LIM_W'(window_q);
		if (win_x > LIM_W'(MAX_WINDOW)) begin
			lim = CNT_W'(MAX_WINDOW);
		end else begin
			lim = win_x[CNT_W-1:0];
		end
	end

	// history sweep starts with the transfer and runs beside the divider
	always_comb begin
		hist_ctl.clr   = accept && bar_in.series_start;
		hist_ctl.sweep = accept && !bar_in.series_start;
		hist_ctl.push  = state_q == S_UPD;
	end

	// VPT update: signed add of the truncated increment, then clamp to 58 bits
	always_comb begin
		if (prev_zero) begin
			inc = '0;
		end else if (div_st.sat) begin
			inc = INC_W'(1) << QUO_W;
		end else begin
			inc = {1'b0, div_st.quo};
		end
		if (neg_q) begin
			acc = ACC_W'(running_q) - $signed({{(ACC_W - INC_W){1'b0}}, inc});
		end else begin
			acc = ACC_W'(running_q) + $signed({{(ACC_W - INC_W){1'b0}}, inc});
		end
		acc_ovf = (acc[ACC_W-1:VPT_W-1] != '0) && (acc[ACC_W-1:VPT_W-1] != '1);
		if (acc_ovf) begin
			vpt_nx = acc[ACC_W-1] ? {1'b1, {(VPT_W - 1){1'b0}}} : {1'b0, {(VPT_W - 1){1'b1}}};
		end else begin
			vpt_nx = acc[VPT_W-1:0];
		end
	end

	vptt_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (num_q),
		.den    (last_close_q),
		.st     (div_st)
	);

	vptt_hist #(
		.MAX_WINDOW (MAX_WINDOW)
	) u_hist (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (hist_ctl),
		.lim       (lim),
		.push_data (vpt_nx),
		.busy      (hist_busy),
		.look      (hist_look),
		.prior_sum (hist_prior)
	);

	vptt_trend #(
		.MAX_WINDOW (MAX_WINDOW)
	) u_trend (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (state_q == S_UPD),
		.vpt        (vpt_nx),
		.look       (hist_look),
		.prior_sum  (hist_prior),
		.upper_pct  (upper_q),
		.lower_pct  (lower_q),
		.done       (trend_done),
		.trend_code (trend_code)
	);

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q <= WINDOW_RST;
			upper_q  <= UPPER_RST;
			lower_q  <= LOWER_RST;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				REG_WINDOW_LEN: window_q <= cfg_wr_data[WIN_W-1:0];
				REG_UPPER_PCT:  upper_q  <= cfg_wr_data[UP_W-1:0];
				REG_LOWER_PCT:  lower_q  <= cfg_wr_data[LO_W-1:0];
				default: ;
			endcase
		end
	end

	// sequencer and series state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			last_close_q <= '0;
			running_q    <= '0;
			res_valid_q  <= 1'b0;
		end else begin
			if (result_out.ready) begin
				res_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept && bar_in.series_start) begin
						running_q    <= '0;
						last_close_q <= bar_in.close_price;
					end else if (accept) begin
						state_q <= S_MUL;
					end
				end
				S_MUL:  state_q <= S_DIV;
				S_DIV:  state_q <= S_WAIT;
				S_WAIT: begin
					if (!div_st.busy && !hist_busy) begin
						state_q <= S_UPD;
					end
				end
				S_UPD: begin
					running_q    <= vpt_nx;
					last_close_q <= close_q;
					state_q      <= S_TRND;
				end
				S_TRND: begin
					if (trend_done) begin
						state_q <= S_OUT;
					end
				end
				S_OUT: begin
					// load once the output register is free or being emptied
					if (!res_valid_q || result_out.ready) begin
						res_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// bar payload and output payload
	always_ff @(posedge clk) begin
		if (accept && !bar_in.series_start) begin
			close_q <= bar_in.close_price;
			vol_q   <= bar_in.bar_volume;
			neg_q   <= bar_in.close_price < last_close_q;
			mag_q   <= (bar_in.close_price < last_close_q) ?
				last_close_q - bar_in.close_price : bar_in.close_price - last_close_q;
		end
		if (state_q == S_MUL) begin
			num_q <= prod_c;
		end
		if ((state_q == S_OUT) && (!res_valid_q || result_out.ready)) begin
			res_vpt_q   <= running_q;
			res_trend_q <= trend_code;
		end
	end

	assign result_out.valid      = res_valid_q;
	assign result_out.vpt_value  = res_vpt_q;
	assign result_out.trend_code = res_trend_q;

	// divider only runs while the sequencer waits on it
	a_div_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		div_st.busy |-> state_q == S_WAIT)
		else $error("divider busy outside wait state");

	// history sweep must finish before the update writes the ring
	a_sweep_window: assert property (@(posedge clk) disable iff (!arst_n)
		hist_busy |-> (state_q == S_MUL || state_q == S_DIV || state_q == S_WAIT))
		else $error("history sweep outside bar processing");

	// trend result arrives only where the sequencer expects it
	a_trend_done: assert property (@(posedge clk) disable iff (!arst_n)
		trend_done |-> state_q == S_TRND)
		else $error("trend done out of sequence");

endmodule

`default_nettype wire

@@ hdl/vptt_div.sv @@
// Radix-4 restoring divider for the scaled VPT increment, with overflow detect.
`default_nettype none

module vptt_div
	import vptt_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	input  wire logic [NUM_W-1:0]   num,
	input  wire logic [PRICE_W-1:0] den,
	output      div_st_t            st
);

	localparam int HI_LSB = QUO_W - FRAC_W;
	localparam int STEP_W = $clog2(DIV_STEPS);

	logic [PRICE_W-1:0] rem_q;
	logic [PRICE_W-1:0] den_q;
	logic [QUO_W-1:0]   sh_q;
	logic [STEP_W-1:0]  step_q;
	logic               busy_q;
	logic               sat_q;

	logic [PRICE_W:0]   t1, t2;
	logic               g1, g2;
	logic [PRICE_W-1:0] r1, r2;
	logic [PRICE_W-1:0] hi_part;

	assign hi_part = PRICE_W'(num[NUM_W-1:HI_LSB]);

	always_comb begin
		t1 = {rem_q, sh_q[QUO_W-1]};
		g1 = t1 >= {1'b0, den_q};
		r1 = g1 ? PRICE_W'(t1 - {1'b0, den_q}) : t1[PRICE_W-1:0];
		t2 = {r1, sh_q[QUO_W-2]};
		g2 = t2 >= {1'b0, den_q};
		r2 = g2 ? PRICE_W'(t2 - {1'b0, den_q}) : t2[PRICE_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			sat_q  <= 1'b0;
			step_q <= '0;
		end else if (start) begin
			// quotient of 2^58 or more saturates
			if (hi_part >= den) begin
				sat_q  <= 1'b1;
				busy_q <= 1'b0;
			end else begin
				sat_q  <= 1'b0;
				busy_q <= 1'b1;
			end
			step_q <= STEP_W'(DIV_STEPS - 1);
		end else if (busy_q) begin
			step_q <= step_q - 1'b1;
			if (step_q == '0) begin
				busy_q <= 1'b0;
			end
		end
	end

	// dividend bits leave the top, quotient bits enter at the bottom
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= hi_part;
			den_q <= den;
			sh_q  <= {num[HI_LSB-1:0], FRAC_W'(0)};
		end else if (busy_q) begin
			rem_q <= r2;
			sh_q  <= {sh_q[QUO_W-3:0], g1, g2};
		end
	end

	assign st.busy = busy_q;
	assign st.sat  = sat_q;
	assign st.quo  = sh_q;

endmodule

`default_nettype wire

@@ hdl/vptt_hist.sv @@
// VPT history ring in a synchronous memory, with the lookback sum sweep.
`default_nettype none

module vptt_hist
	import vptt_pkg::*;
#(
	parameter  int MAX_WINDOW = MAX_WINDOW_DEF,
	localparam int CNT_W      = $clog2(MAX_WINDOW + 1),
	localparam int PTR_W      = $clog2(MAX_WINDOW),
	localparam int SUM_W      = VPT_W + CNT_W
)(
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire hist_ctl_t               ctl,
	input  wire logic        [CNT_W-1:0] lim,
	input  wire logic signed [VPT_W-1:0] push_data,
	output      logic                    busy,
	output      logic        [CNT_W-1:0] look,
	output      logic signed [SUM_W-1:0] prior_sum
);

	logic signed [VPT_W-1:0] mem [MAX_WINDOW];

	logic        [PTR_W-1:0] ptr_q;
	logic        [CNT_W-1:0] cnt_q;
	logic        [PTR_W-1:0] rd_idx_q;
	logic        [CNT_W-1:0] left_q;
	logic        [CNT_W-1:0] look_q;
	logic                    rd_v_s1;
	logic signed [VPT_W-1:0] rdata_s1;
	logic signed [SUM_W-1:0] acc_q;

	logic                    rd_en;
	logic        [CNT_W-1:0] cnt_nx;
	logic        [CNT_W-1:0] look_c;
	logic        [CNT_W-1:0] nreads_c;
	logic        [PTR_W-1:0] ptr_prev;
	logic        [PTR_W-1:0] ptr_next;
	logic        [PTR_W-1:0] rd_prev;

	assign rd_en = left_q != '0;

	always_comb begin
		cnt_nx   = (cnt_q == CNT_W'(MAX_WINDOW)) ? cnt_q : cnt_q + 1'b1;
		look_c   = (cnt_nx < lim) ? cnt_nx : lim;
		// the newest value is the bar in flight, not yet in memory
		nreads_c = (look_c >= CNT_W'(2)) ? look_c - 1'b1 : '0;
		ptr_prev = (ptr_q == '0) ? PTR_W'(MAX_WINDOW - 1) : ptr_q - 1'b1;
		ptr_next = (ptr_q == PTR_W'(MAX_WINDOW - 1)) ? '0 : ptr_q + 1'b1;
		rd_prev  = (rd_idx_q == '0) ? PTR_W'(MAX_WINDOW - 1) : rd_idx_q - 1'b1;
	end

	always_ff @(posedge clk) begin
		if (ctl.push) begin
			mem[ptr_q] <= push_data;
		end
		if (rd_en) begin
			rdata_s1 <= mem[rd_idx_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q    <= '0;
			cnt_q    <= '0;
			rd_idx_q <= '0;
			left_q   <= '0;
			look_q   <= '0;
			rd_v_s1  <= 1'b0;
			acc_q    <= '0;
		end else begin
			rd_v_s1 <= rd_en;
			if (ctl.clr) begin
				ptr_q  <= '0;
				cnt_q  <= '0;
				left_q <= '0;
			end else if (ctl.sweep) begin
				look_q   <= look_c;
				left_q   <= nreads_c;
				rd_idx_q <= ptr_prev;
				acc_q    <= '0;
			end else begin
				if (rd_en) begin
					rd_idx_q <= rd_prev;
					left_q   <= left_q - 1'b1;
				end
				if (rd_v_s1) begin
					acc_q <= acc_q + SUM_W'(rdata_s1);
				end
				if (ctl.push) begin
					ptr_q <= ptr_next;
					cnt_q <= cnt_nx;
				end
			end
		end
	end

	assign busy      = rd_en || rd_v_s1;
	assign look      = look_q;
	assign prior_sum = acc_q;

endmodule

`default_nettype wire

@@ hdl/vptt_trend.sv @@
// Trend decision: cross-multiplied compare of VPT against the window average.
`default_nettype none

module vptt_trend
	import vptt_pkg::*;
#(
	parameter  int MAX_WINDOW = MAX_WINDOW_DEF,
	localparam int CNT_W      = $clog2(MAX_WINDOW + 1),
	localparam int SUM_W      = VPT_W + CNT_W
)(
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      start,
	input  wire logic signed [VPT_W-1:0]   vpt,
	input  wire logic        [CNT_W-1:0]   look,
	input  wire logic signed [SUM_W-1:0]   prior_sum,
	input  wire logic        [UP_W-1:0]    upper_pct,
	input  wire logic        [LO_W-1:0]    lower_pct,
	output      logic                      done,
	output      logic        [TREND_W-1:0] trend_code
);

	localparam int P_W   = VPT_W + CNT_W + 1;
	localparam int LHS_W = P_W + 8;
	localparam int RHS_W = SUM_W + UP_W + 1;
	localparam int CMP_W = ((LHS_W > RHS_W) ? LHS_W : RHS_W) + 1;

	logic                      v_s1, v_s2, v_s3, done_q;
	logic                      ok_s1, ok_s2, ok_s3;
	logic signed [SUM_W-1:0]   sum_s1;
	logic signed [VPT_W-1:0]   vpt_s1;
	logic        [CNT_W-1:0]   look_s1;
	logic signed [P_W-1:0]     p_s2;
	logic signed [RHS_W-1:0]   hu_s2, hl_s2, hu_s3, hl_s3;
	logic signed [LHS_W-1:0]   lhs_s3;
	logic        [TREND_W-1:0] trend_q;

	logic signed [CMP_W-1:0]   lhs_x, hu_x, hl_x;
	logic        [TREND_W-1:0] trend_c;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1   <= 1'b0;
			v_s2   <= 1'b0;
			v_s3   <= 1'b0;
			done_q <= 1'b0;
		end else begin
			v_s1   <= start;
			v_s2   <= v_s1;
			v_s3   <= v_s2;
			done_q <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		// s1: window sum including the newest value
		sum_s1  <= prior_sum + SUM_W'(vpt);
		vpt_s1  <= vpt;
		look_s1 <= look;
		ok_s1   <= look >= CNT_W'(2);
		// s2: products
		p_s2  <= vpt_s1 * $signed({1'b0, look_s1});
		hu_s2 <= sum_s1 * $signed({1'b0, upper_pct});
		hl_s2 <= sum_s1 * $signed({2'b0, lower_pct});
		ok_s2 <= ok_s1;
		// s3: percentage scale on the VPT side
		lhs_s3 <= p_s2 * $signed(8'(PCT_SCALE));
		hu_s3  <= hu_s2;
		hl_s3  <= hl_s2;
		ok_s3  <= ok_s2;
		if (v_s3) begin
			trend_q <= trend_c;
		end
	end

	always_comb begin
		lhs_x = CMP_W'(lhs_s3);
		hu_x  = CMP_W'(hu_s3);
		hl_x  = CMP_W'(hl_s3);
		// bullish wins over bearish
		if (!ok_s3) begin
			trend_c = TREND_NEUTRAL;
		end else if (lhs_x > hu_x) begin
			trend_c = TREND_BULL;
		end else if (hl_x > lhs_x) begin
			trend_c = TREND_BEAR;
		end else begin
			trend_c = TREND_NEUTRAL;
		end
	end

	assign done       = done_q;
	assign trend_code = trend_q;

endmodule

`default_nettype wire
